@@ hdl/top_k_threshold_selector_unit_defines.svh @@
// Assertion macros shared by the top-K threshold selector RTL.
`ifndef TOP_K_THRESHOLD_SELECTOR_UNIT_DEFINES_SVH
`define TOP_K_THRESHOLD_SELECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TKTS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("top-k selector check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TKTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("top-k selector check failed");

`else

`define TKTS_ASSERT_IMPLIES(label, ante, cons)
`define TKTS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hdl/tkts_pkg.sv @@
// Shared constants, codes and interface types of the top-K threshold selector.
`timescale 1ns / 1ps

package tkts_pkg;

    localparam int CAPACITY   = 16;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KEEP_W     = 5;
    localparam int KCMP_W     = (COUNT_W > KEEP_W) ? COUNT_W : KEEP_W;
    localparam int ID_W       = 20;
    localparam int UTIL_W     = 48;
    localparam int GAIN_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

    typedef enum logic
    {
        CMD_OFFER = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_code_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_KEEP = 2'd0,
        CFG_SEED = 2'd1,
        CFG_GAIN = 2'd2
    } cfg_index_t;

    typedef enum logic
    {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic offer;
        logic drain_step;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic               drain_last;
        logic [COUNT_W-1:0] held_count;
    } dp_status_t;

endpackage

@@ hdl/top_k_threshold_selector_unit.sv @@
// Top level of the top-K threshold selector: controller, datapath and checks.
//
// Usage. Items arrive on the input channel (in_valid/in_ready) and each
// transfer carries a command: an offer of a candidate, or a drain. An offer
// is judged and, if admitted, placed into the sorted store in the same cycle
// as its transfer; it produces no result, and the next item may follow in
// the very next cycle. A drain closes the input channel while it runs: its
// transfer first moves the controller into its drain state, from which the
// first result is registered and appears on the output channel
// (out_valid/out_ready). One result per cycle then follows while the receiver
// keeps out_ready high, best utility first. A drain of an empty store
// yields a single result with entry_valid low and last_entry high.
// When the receiver stalls, the result register simply holds its transfer
// and the drain waits; a new offer can be taken while the final result of
// a drain is still waiting to be collected. Configuration writes
// (cfg_valid/cfg_ready) are always accepted. Reset clears the store count
// and loads the default registers; the entry store itself needs no
// clearing pass, so the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`include "top_k_threshold_selector_unit_defines.svh"

module top_k_threshold_selector_unit
    import tkts_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic [ID_W-1:0]          item_id,
    input  logic signed [UTIL_W-1:0] utility,
    input  logic signed [GAIN_W-1:0] gain,
    input  logic                     gain_defined,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     entry_valid,
    output logic [ID_W-1:0]          out_item_id,
    output logic signed [UTIL_W-1:0] out_utility,
    output logic signed [GAIN_W-1:0] out_gain,
    output logic                     last_entry
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Register writes never wait: each one is accepted as soon as it is offered.
    assign cfg_ready = 1'b1;

    // The controller owns both handshakes and walks the store during a drain.
    tkts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    // The datapath holds the sorted store, the thresholds and the result register.
    tkts_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .dp_status    (dp_status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_id      (item_id),
        .utility      (utility),
        .gain         (gain),
        .gain_defined (gain_defined),
        .entry_valid  (entry_valid),
        .out_item_id  (out_item_id),
        .out_utility  (out_utility),
        .out_gain     (out_gain),
        .last_entry   (last_entry)
    );

    // A drain transfer closes the input channel for at least the next cycle.
    `TKTS_ASSERT_NEXT(a_drain_blocks_input, in_valid && in_ready && (command == CMD_DRAIN), !in_ready)

    // A result without a held entry only ever ends a drain.
    `TKTS_ASSERT_IMPLIES(a_empty_result_is_last, out_valid && !entry_valid, last_entry)

    // The store never holds more entries than it has room for.
    `TKTS_ASSERT_IMPLIES(a_count_in_range, 1'b1, dp_status.held_count <= COUNT_W'(CAPACITY))

endmodule

@@ hdl/tkts_ctrl.sv @@
// Controller state machine: input and output handshakes and drain sequencing.
`timescale 1ns / 1ps

module tkts_ctrl
    import tkts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    dp_cmd,
    input  dp_status_t dp_status
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        in_ready           = 1'b0;
        dp_cmd.offer       = 1'b0;
        dp_cmd.drain_step  = 1'b0;
        out_valid_next     = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (cmd_code_t'(command) == CMD_DRAIN)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        dp_cmd.offer = 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                // One held entry moves to the output register whenever it has room.
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.drain_step = 1'b1;
                    out_valid_next    = 1'b1;
                    if (dp_status.drain_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hdl/tkts_dpath.sv @@
// Datapath: sorted entry store, admission threshold, registers and result register.
`timescale 1ns / 1ps

module tkts_dpath
    import tkts_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  dp_cmd,
    output dp_status_t               dp_status,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic [ID_W-1:0]          item_id,
    input  logic signed [UTIL_W-1:0] utility,
    input  logic signed [GAIN_W-1:0] gain,
    input  logic                     gain_defined,
    output logic                     entry_valid,
    output logic [ID_W-1:0]          out_item_id,
    output logic signed [UTIL_W-1:0] out_utility,
    output logic signed [GAIN_W-1:0] out_gain,
    output logic                     last_entry
);

    // Entry store, kept sorted from best (index 0) to worst.
    logic signed [UTIL_W-1:0] util_reg [CAPACITY];
    logic [ID_W-1:0]          item_reg [CAPACITY];
    logic signed [GAIN_W-1:0] gain_reg [CAPACITY];
    logic signed [UTIL_W-1:0] util_next [CAPACITY];
    logic [ID_W-1:0]          item_next [CAPACITY];
    logic signed [GAIN_W-1:0] gain_next [CAPACITY];

    logic signed [UTIL_W-1:0] ins_util [CAPACITY];
    logic [ID_W-1:0]          ins_item [CAPACITY];
    logic signed [GAIN_W-1:0] ins_gain [CAPACITY];

    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic signed [UTIL_W-1:0] thr_reg;
    logic signed [UTIL_W-1:0] thr_next;
    logic signed [UTIL_W-1:0] seed_reg;
    logic signed [UTIL_W-1:0] seed_next;
    logic signed [GAIN_W-1:0] gthr_reg;
    logic signed [GAIN_W-1:0] gthr_next;
    logic [KEEP_W-1:0]        keep_reg;
    logic [KEEP_W-1:0]        keep_next;

    logic                     ent_valid_reg;
    logic                     ent_valid_next;
    logic                     last_reg;
    logic                     last_next;
    logic [ID_W-1:0]          o_item_reg;
    logic [ID_W-1:0]          o_item_next;
    logic signed [UTIL_W-1:0] o_util_reg;
    logic signed [UTIL_W-1:0] o_util_next;
    logic signed [GAIN_W-1:0] o_gain_reg;
    logic signed [GAIN_W-1:0] o_gain_next;

    logic [CAPACITY-1:0]      held_v;
    logic [CAPACITY-1:0]      ge_v;
    logic                     any_lt;
    logic [KCMP_W-1:0]        keep_ext;
    logic [COUNT_W-1:0]       k_eff;
    logic                     below_k;
    logic                     admit;
    logic                     do_ins;
    logic                     do_rep;
    logic [COUNT_W-1:0]       count_inc;
    logic [COUNT_W-1:0]       last_pos;
    logic [IDX_W-1:0]         last_idx;
    logic signed [UTIL_W-1:0] cfg_seed_val;

    // Effective K: zero counts as one, anything above the capacity saturates.
    always_comb
    begin
        keep_ext = KCMP_W'(keep_reg);
        if (keep_reg == '0)
        begin
            k_eff = COUNT_W'(1);
        end
        else if (keep_ext > KCMP_W'(CAPACITY))
        begin
            k_eff = COUNT_W'(CAPACITY);
        end
        else
        begin
            k_eff = COUNT_W'(keep_ext);
        end
    end

    assign below_k   = count_reg < k_eff;
    assign count_inc = count_reg + COUNT_W'(1);

    // Per-entry rank compare; the ge mask is a prefix because the store is sorted.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            held_v[i] = COUNT_W'(i) < count_reg;
            ge_v[i]   = held_v[i] && (util_reg[i] >= utility);
        end
        any_lt = |(held_v & ~ge_v);

        ins_util[0] = ge_v[0] ? util_reg[0] : utility;
        ins_item[0] = ge_v[0] ? item_reg[0] : item_id;
        ins_gain[0] = ge_v[0] ? gain_reg[0] : gain;
        for (int i = 1; i < CAPACITY; i++)
        begin
            if (ge_v[i])
            begin
                ins_util[i] = util_reg[i];
                ins_item[i] = item_reg[i];
                ins_gain[i] = gain_reg[i];
            end
            else if (ge_v[i-1])
            begin
                ins_util[i] = utility;
                ins_item[i] = item_id;
                ins_gain[i] = gain;
            end
            else
            begin
                ins_util[i] = util_reg[i-1];
                ins_item[i] = item_reg[i-1];
                ins_gain[i] = gain_reg[i-1];
            end
        end
    end

    assign admit = dp_cmd.offer
                && !(utility < thr_reg)
                && !(utility[UTIL_W-1] || (utility == '0))
                && gain_defined
                && (gain > gthr_reg);
    assign do_ins = admit && below_k;
    assign do_rep = admit && !below_k && (count_reg != '0) && any_lt;

    // Position of the worst entry after an insertion or a replacement.
    assign last_pos     = do_ins ? count_reg : count_reg - COUNT_W'(1);
    assign last_idx     = last_pos[IDX_W-1:0];
    assign cfg_seed_val = cfg_data[UTIL_W-1:0];

    always_comb
    begin
        util_next      = util_reg;
        item_next      = item_reg;
        gain_next      = gain_reg;
        count_next     = count_reg;
        thr_next       = thr_reg;
        seed_next      = seed_reg;
        gthr_next      = gthr_reg;
        keep_next      = keep_reg;
        ent_valid_next = ent_valid_reg;
        last_next      = last_reg;
        o_item_next    = o_item_reg;
        o_util_next    = o_util_reg;
        o_gain_next    = o_gain_reg;

        if (do_ins || do_rep)
        begin
            util_next = ins_util;
            item_next = ins_item;
            gain_next = ins_gain;
            if (do_ins)
            begin
                count_next = count_inc;
            end
            if (do_rep || (count_inc >= k_eff))
            begin
                thr_next = ins_util[last_idx];
            end
        end

        if (dp_cmd.drain_step)
        begin
            ent_valid_next = count_reg != '0;
            last_next      = count_reg <= COUNT_W'(1);
            o_item_next    = (count_reg != '0) ? item_reg[0] : '0;
            o_util_next    = (count_reg != '0) ? util_reg[0] : '0;
            o_gain_next    = (count_reg != '0) ? gain_reg[0] : '0;
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                util_next[i] = util_reg[i+1];
                item_next[i] = item_reg[i+1];
                gain_next[i] = gain_reg[i+1];
            end
            if (count_reg != '0)
            begin
                count_next = count_reg - COUNT_W'(1);
            end
            if (count_reg <= COUNT_W'(1))
            begin
                thr_next = seed_reg;
            end
        end

        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KEEP:
                begin
                    keep_next = cfg_data[KEEP_W-1:0];
                end
                CFG_SEED:
                begin
                    seed_next = cfg_seed_val;
                    if (below_k)
                    begin
                        thr_next = cfg_seed_val;
                    end
                end
                CFG_GAIN:
                begin
                    gthr_next = cfg_data[GAIN_W-1:0];
                end
                default:
                begin
                    keep_next = keep_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            thr_reg   <= '0;
            seed_reg  <= '0;
            gthr_reg  <= '0;
            keep_reg  <= KEEP_RESET;
        end
        else
        begin
            count_reg <= count_next;
            thr_reg   <= thr_next;
            seed_reg  <= seed_next;
            gthr_reg  <= gthr_next;
            keep_reg  <= keep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        util_reg      <= util_next;
        item_reg      <= item_next;
        gain_reg      <= gain_next;
        ent_valid_reg <= ent_valid_next;
        last_reg      <= last_next;
        o_item_reg    <= o_item_next;
        o_util_reg    <= o_util_next;
        o_gain_reg    <= o_gain_next;
    end

    assign dp_status.drain_last = count_reg <= COUNT_W'(1);
    assign dp_status.held_count = count_reg;

    assign entry_valid = ent_valid_reg;
    assign last_entry  = last_reg;
    assign out_item_id = o_item_reg;
    assign out_utility = o_util_reg;
    assign out_gain    = o_gain_reg;

endmodule
